[rtl/core/rdof_pkg.sv]
// ----------------------------------------------------------------------------
// rdof_pkg
// Types and constants shared by the ROI mean-depth obstacle flag block.
// ----------------------------------------------------------------------------
package rdof_pkg;

	localparam int unsigned MAX_SIDE = 2048;

	localparam int unsigned DEPTH_W = 16;
	localparam int unsigned COORD_W = 11;
	localparam int unsigned RECT_W  = 48;
	localparam int unsigned SUM_W   = 38;
	localparam int unsigned CNT_W   = 22;
	localparam int unsigned PROD_W  = DEPTH_W + CNT_W;
	localparam int unsigned CFG_W   = RECT_W;

	typedef logic [RECT_W-1:0]  rect_t;
	typedef logic [DEPTH_W-1:0] level_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [PROD_W-1:0]  prod_t;

	typedef enum logic [2:0] {
		REG_STRAIGHT_RECT  = 3'd0,
		REG_RIGHT_RECT     = 3'd1,
		REG_STRAIGHT_LEVEL = 3'd2,
		REG_RIGHT_LEVEL    = 3'd3,
		REG_DEPTH_MARGIN   = 3'd4
	} cfg_idx_t;

	localparam rect_t  STRAIGHT_RECT_RST  = 48'd5497894297680;
	localparam rect_t  RIGHT_RECT_RST     = 48'd31611295580260;
	localparam level_t STRAIGHT_LEVEL_RST = 16'd1750;
	localparam level_t RIGHT_LEVEL_RST    = 16'd1550;
	localparam level_t DEPTH_MARGIN_RST   = 16'd200;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_end;
	} pixel_t;

	typedef struct packed {
		logic straight_blocked;
		logic right_blocked;
	} flags_t;

	typedef struct packed {
		logic load_s2;
		logic consume_s2;
		logic snap;
		logic load_s4;
	} stage_ctl_t;

endpackage

[rtl/core/rdof_region.sv]
// ----------------------------------------------------------------------------
// rdof_region
// Membership test, saturating sum and count of nonzero depth pixels for one
// rectangle, frame-end snapshot and the division-free mean comparison.
// ----------------------------------------------------------------------------
module rdof_region (
	input  logic                clk,
	input  logic                arst_n,
	input  rdof_pkg::rect_t     rect,
	input  rdof_pkg::level_t    thr,
	input  rdof_pkg::pixel_t    pix_s1,
	input  rdof_pkg::stage_ctl_t ctl,
	output logic                nonempty,
	output logic                blocked
);
	import rdof_pkg::*;

	logic [COORD_W-1:0] x0, y0, w, h;
	logic [COORD_W:0]   x_end, y_end;
	logic               in_image, hit_s1;

	logic               hit_s2;
	logic [DEPTH_W-1:0] depth_s2;

	sum_t               sum_q, sum_nx;
	cnt_t               count_q, count_nx;
	logic [SUM_W:0]     sum_add;

	sum_t               sum_s3;
	cnt_t               count_s3;
	prod_t              prod_s4;
	sum_t               sum_s4;

	assign x0 = rect[47:37];
	assign y0 = rect[35:25];
	assign w  = rect[23:13];
	assign h  = rect[11:1];

	assign x_end = {1'b0, x0} + {1'b0, w};
	assign y_end = {1'b0, y0} + {1'b0, h};

	assign in_image = (32'(pix_s1.col) < MAX_SIDE) && (32'(pix_s1.row) < MAX_SIDE);

	assign hit_s1 = (pix_s1.depth != '0) && in_image
		&& (pix_s1.col >= x0) && ({1'b0, pix_s1.col} < x_end)
		&& (pix_s1.row >= y0) && ({1'b0, pix_s1.row} < y_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else if (ctl.load_s2) begin
			hit_s2 <= hit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			depth_s2 <= pix_s1.depth;
		end
	end

	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(depth_s2);

	always_comb begin
		sum_nx   = sum_q;
		count_nx = count_q;
		if (hit_s2) begin
			sum_nx = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
			if (count_q != '1) begin
				count_nx = count_q + 1'b1;
			end
		end
	end

	assign nonempty = (count_nx != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctl.consume_s2) begin
			if (ctl.snap) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_nx;
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.snap) begin
			sum_s3   <= sum_nx;
			count_s3 <= count_nx;
		end
		if (ctl.load_s4) begin
			prod_s4 <= PROD_W'(thr) * PROD_W'(count_s3);
			sum_s4  <= sum_s3;
		end
	end

	assign blocked = (prod_s4 > sum_s4);

endmodule

[rtl/core/roi_mean_depth_obstacle_flags.sv]
// ----------------------------------------------------------------------------
// roi_mean_depth_obstacle_flags
// Accumulates nonzero depth pixels in two rectangles and, at a frame end with
// both nonempty, reports if each region's mean depth lies below its threshold.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Item
// pixel     in         pixel_valid/stall      depth, col, row, frame_end
// flags     out        flags_valid/stall      straight_blocked, right_blocked
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// One pixel is taken every cycle while pixel_stall is low; each pixel only
// updates two accumulators. A frame-end pixel's flags pass through the input
// register, the accumulator stage, the snapshot and the multiplier stage to
// the output register.
// Reset clears all accumulators and valid bits and restores default settings.
// While flags are stalled, pixels keep flowing until a frame-end item finds
// the result stages full.
module roi_mean_depth_obstacle_flags (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  rdof_pkg::pixel_t   pixel,
	output logic               flags_valid,
	input  logic               flags_stall,
	output rdof_pkg::flags_t   flags,
	input  logic               cfg_we,
	input  rdof_pkg::cfg_idx_t cfg_index,
	input  logic [rdof_pkg::CFG_W-1:0] cfg_data
);
	import rdof_pkg::*;

	rect_t  straight_rect_q, right_rect_q;
	level_t straight_level_q, right_level_q, depth_margin_q;
	level_t straight_thr, right_thr;

	pixel_t pix_s1;
	logic   valid_s1, valid_s2, fend_s2, valid_s3, valid_s4;
	logic   ready_s1, ready_s2, ready_s3, ready_s4, ready_out;
	logic   accept;
	stage_ctl_t ctl;
	logic   st_nonempty, rt_nonempty, st_blocked, rt_blocked;
	flags_t flags_q;
	logic   flags_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_rect_q  <= STRAIGHT_RECT_RST;
			right_rect_q     <= RIGHT_RECT_RST;
			straight_level_q <= STRAIGHT_LEVEL_RST;
			right_level_q    <= RIGHT_LEVEL_RST;
			depth_margin_q   <= DEPTH_MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRAIGHT_RECT:  straight_rect_q  <= cfg_data;
				REG_RIGHT_RECT:     right_rect_q     <= cfg_data;
				REG_STRAIGHT_LEVEL: straight_level_q <= cfg_data[DEPTH_W-1:0];
				REG_RIGHT_LEVEL:    right_level_q    <= cfg_data[DEPTH_W-1:0];
				REG_DEPTH_MARGIN:   depth_margin_q   <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// A level at or below the margin gives a zero threshold, which never blocks.
	assign straight_thr = (straight_level_q > depth_margin_q)
		? straight_level_q - depth_margin_q : '0;
	assign right_thr = (right_level_q > depth_margin_q)
		? right_level_q - depth_margin_q : '0;

	assign ready_out = !flags_valid_q || !flags_stall;
	assign ready_s4  = !valid_s4 || ready_out;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || !fend_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;

	assign pixel_stall = !ready_s1;
	assign accept      = pixel_valid && ready_s1;

	assign ctl.load_s2    = valid_s1 && ready_s2;
	assign ctl.consume_s2 = valid_s2 && ready_s2;
	assign ctl.snap       = valid_s2 && fend_s2 && ready_s2;
	assign ctl.load_s4    = valid_s3 && ready_s4;

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			fend_s2       <= 1'b0;
			valid_s3      <= 1'b0;
			valid_s4      <= 1'b0;
			flags_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (ctl.load_s2) begin
				valid_s1 <= 1'b0;
			end

			if (ctl.load_s2) begin
				valid_s2 <= 1'b1;
				fend_s2  <= pix_s1.frame_end;
			end else if (ctl.consume_s2) begin
				valid_s2 <= 1'b0;
			end

			if (ctl.snap) begin
				valid_s3 <= st_nonempty && rt_nonempty;
			end else if (ctl.load_s4) begin
				valid_s3 <= 1'b0;
			end

			if (ctl.load_s4) begin
				valid_s4 <= 1'b1;
			end else if (ready_out) begin
				valid_s4 <= 1'b0;
			end

			if (valid_s4 && ready_out) begin
				flags_valid_q <= 1'b1;
			end else if (!flags_stall) begin
				flags_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && ready_out) begin
			flags_q.straight_blocked <= st_blocked;
			flags_q.right_blocked    <= rt_blocked;
		end
	end

	rdof_region u_straight (
		.clk      (clk),
		.arst_n   (arst_n),
		.rect     (straight_rect_q),
		.thr      (straight_thr),
		.pix_s1   (pix_s1),
		.ctl      (ctl),
		.nonempty (st_nonempty),
		.blocked  (st_blocked)
	);

	rdof_region u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.rect     (right_rect_q),
		.thr      (right_thr),
		.pix_s1   (pix_s1),
		.ctl      (ctl),
		.nonempty (rt_nonempty),
		.blocked  (rt_blocked)
	);

	assign flags_valid = flags_valid_q;
	assign flags       = flags_q;

endmodule

[dv/rdof_flags_sb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdof_flags_sb_pkg
// Predicts the obstacle flags from every accepted pixel and the current
// settings, keeps the flags still owed by the block, and checks each flags
// item that leaves it against the oldest one owed.
// ----------------------------------------------------------------------------
package rdof_flags_sb_pkg;

	import rdof_pkg::*;

	class flag_predictor;
		rect_t  straight_rect;
		rect_t  right_rect;
		level_t straight_level;
		level_t right_level;
		level_t depth_margin;
		sum_t   straight_sum;
		sum_t   right_sum;
		cnt_t   straight_count;
		cnt_t   right_count;
		logic   straight_flag;
		logic   right_flag;
		flags_t expected_flags[$];
		int unsigned mismatches;

		function new();
			straight_rect  = STRAIGHT_RECT_RST;
			right_rect     = RIGHT_RECT_RST;
			straight_level = STRAIGHT_LEVEL_RST;
			right_level    = RIGHT_LEVEL_RST;
			depth_margin   = DEPTH_MARGIN_RST;
			straight_sum   = '0;
			right_sum      = '0;
			straight_count = '0;
			right_count    = '0;
			straight_flag  = 1'b0;
			right_flag     = 1'b0;
			mismatches     = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
			REG_STRAIGHT_RECT: begin
				straight_rect = data;
			end
			REG_RIGHT_RECT: begin
				right_rect = data;
			end
			REG_STRAIGHT_LEVEL: begin
				straight_level = data[DEPTH_W-1:0];
			end
			REG_RIGHT_LEVEL: begin
				right_level = data[DEPTH_W-1:0];
			end
			REG_DEPTH_MARGIN: begin
				depth_margin = data[DEPTH_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		// Every rectangle field is used as stored, without scaling.
		static function bit covers(rect_t r, logic [COORD_W-1:0] c, logic [COORD_W-1:0] rw);
			logic [12:0] x0;
			logic [12:0] y0;
			logic [12:0] w;
			logic [12:0] h;
			x0 = 13'(r[47:37]);
			y0 = 13'(r[35:25]);
			w  = 13'(r[23:13]);
			h  = 13'(r[11:1]);
			return 13'(c) >= x0 && 13'(c) < x0 + w && 13'(rw) >= y0 && 13'(rw) < y0 + h;
		endfunction

		static function sum_t sat_sum(sum_t s, logic [DEPTH_W-1:0] d);
			logic [SUM_W:0] t;
			t = {1'b0, s} + (SUM_W+1)'(d);
			return t[SUM_W] ? '1 : t[SUM_W-1:0];
		endfunction

		static function cnt_t sat_count(cnt_t n);
			return (n == '1) ? n : n + 1'b1;
		endfunction

		function logic region_blocked(level_t lv, sum_t s, cnt_t n);
			logic [63:0] floor_total;
			if (lv <= depth_margin)
				return 1'b0;
			floor_total = 64'(lv - depth_margin) * 64'(n);
			return floor_total > 64'(s);
		endfunction

		function void take_pixel(pixel_t p);
			flags_t f;
			if (p.depth != '0 && 32'(p.col) < MAX_SIDE && 32'(p.row) < MAX_SIDE) begin
				if (covers(straight_rect, p.col, p.row)) begin
					straight_sum   = sat_sum(straight_sum, p.depth);
					straight_count = sat_count(straight_count);
				end
				if (covers(right_rect, p.col, p.row)) begin
					right_sum   = sat_sum(right_sum, p.depth);
					right_count = sat_count(right_count);
				end
			end
			if (p.frame_end) begin
				if (straight_count != '0 && right_count != '0) begin
					straight_flag = region_blocked(straight_level, straight_sum, straight_count);
					right_flag    = region_blocked(right_level, right_sum, right_count);
					f.straight_blocked = straight_flag;
					f.right_blocked    = right_flag;
					expected_flags = {expected_flags, f};
				end
				straight_sum   = '0;
				right_sum      = '0;
				straight_count = '0;
				right_count    = '0;
			end
		endfunction

		function void check_flags(flags_t got);
			flags_t want;
			if (expected_flags.size() == 0) begin
				$display("%0t: flags item %b arrived, expected none", $time, got);
				mismatches++;
				return;
			end
			want = expected_flags.pop_front();
			if (got.straight_blocked !== want.straight_blocked) begin
				$display("%0t: straight_blocked expected %b, actual %b", $time,
					want.straight_blocked, got.straight_blocked);
				mismatches++;
			end
			if (got.right_blocked !== want.right_blocked) begin
				$display("%0t: right_blocked expected %b, actual %b", $time,
					want.right_blocked, got.right_blocked);
				mismatches++;
			end
		endfunction
	endclass

endpackage

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives depth pixels in bursts through several sets of rectangles, levels and
// margins, stalls the flags at random, and checks every flags item against
// the predicted mean-depth decision of both regions.
// ----------------------------------------------------------------------------
module tb;

	import rdof_pkg::*;
	import rdof_flags_sb_pkg::*;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             pixel_valid = 1'b0;
	pixel_t           pixel       = '0;
	logic             flags_stall = 1'b0;
	logic             cfg_we      = 1'b0;
	cfg_idx_t         cfg_index   = REG_STRAIGHT_RECT;
	logic [CFG_W-1:0] cfg_data    = '0;
	logic             pixel_stall;
	logic             flags_valid;
	flags_t           flags;

	flag_predictor sb;
	int unsigned   burst_left = 0;
	int unsigned   stall_mode = 0;
	int unsigned   stall_hold = 0;

	roi_mean_depth_obstacle_flags u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.flags_valid(flags_valid),
		.flags_stall(flags_stall),
		.flags      (flags),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (pixel_valid && !pixel_stall)
				sb.take_pixel(pixel);
			if (flags_valid && !flags_stall)
				sb.check_flags(flags);
		end
	end

	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_hold <= $urandom_range(20, 200);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
		0: begin
			flags_stall <= 1'b0;
		end
		1: begin
			flags_stall <= ($urandom_range(0, 1) == 0);
		end
		2: begin
			flags_stall <= ($urandom_range(0, 3) != 0);
		end
		default: begin
			flags_stall <= stall_hold[4];
		end
		endcase
	end

	task automatic send_pixel(input logic [DEPTH_W-1:0] d, input logic [COORD_W-1:0] c,
		input logic [COORD_W-1:0] rw, input logic fe);
		pixel_t p;
		p.depth     = d;
		p.col       = c;
		p.row       = rw;
		p.frame_end = fe;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 2) != 0) begin
				pixel_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		do @(posedge clk); while (pixel_stall);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic load_settings(input rect_t s_rect, input rect_t r_rect,
		input logic [CFG_W-1:0] s_level, input logic [CFG_W-1:0] r_level,
		input logic [CFG_W-1:0] margin);
		put_reg(REG_STRAIGHT_RECT, s_rect);
		put_reg(REG_RIGHT_RECT, r_rect);
		put_reg(REG_STRAIGHT_LEVEL, s_level);
		put_reg(REG_RIGHT_LEVEL, r_level);
		put_reg(REG_DEPTH_MARGIN, margin);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Pixels without a result may still sit in the pipeline after the last
	// flags item, so the task keeps waiting before the block counts as idle.
	task automatic drain();
		pixel_valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_flags.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	function automatic logic [DEPTH_W-1:0] thr_of(level_t lv);
		return (lv > sb.depth_margin) ? lv - sb.depth_margin : lv;
	endfunction

	function automatic logic [DEPTH_W-1:0] near_depth(logic [DEPTH_W-1:0] thr, bit low_side);
		int d;
		int delta;
		delta = $urandom_range(0, 40);
		d = low_side ? int'(thr) - delta : int'(thr) + delta;
		if (d < 1)
			d = 1;
		if (d > 65535)
			d = 65535;
		return d[DEPTH_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(logic [10:0] lo, logic [10:0] len);
		logic [12:0] hi;
		int unsigned sel;
		if (len == '0)
			return 11'($urandom_range(0, 2047));
		hi = 13'(lo) + 13'(len) - 13'd1;
		if (hi > 13'd2047)
			hi = 13'd2047;
		sel = $urandom_range(0, 4);
		if (sel == 0)
			return lo;
		else if (sel == 1)
			return hi[10:0];
		return 11'($urandom_range(lo, hi));
	endfunction

	function automatic void point_in(rect_t r, output logic [COORD_W-1:0] c,
		output logic [COORD_W-1:0] rw);
		c  = pick_coord(r[47:37], r[23:13]);
		rw = pick_coord(r[35:25], r[11:1]);
	endfunction

	function automatic rect_t roi_rect();
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] w;
		logic [11:0] h;
		if ($urandom_range(0, 3) == 0)
			return 48'({$urandom(), $urandom()});
		x = 12'($urandom_range(0, 4095));
		y = 12'($urandom_range(0, 4095));
		w = 12'($urandom_range(2, 60));
		h = 12'($urandom_range(2, 60));
		return {x, y, w, h};
	endfunction

	task automatic region_pixel(input rect_t r, input logic [DEPTH_W-1:0] thr,
		input bit low_side, input logic fe);
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] rw;
		logic [DEPTH_W-1:0] d;
		point_in(r, c, rw);
		if ($urandom_range(0, 7) == 0)
			d = 16'($urandom_range(1, 65535));
		else
			d = near_depth(thr, low_side);
		send_pixel(d, c, rw, fe);
	endtask

	task automatic directed_frames();
		logic [COORD_W-1:0] sx0, sy0, sx1, sy1, rx0, ry0, rx1, ry1;
		logic [DEPTH_W-1:0] s_thr, r_thr;
		sx0   = sb.straight_rect[47:37];
		sy0   = sb.straight_rect[35:25];
		sx1   = sx0 + sb.straight_rect[23:13] - 1'b1;
		sy1   = sy0 + sb.straight_rect[11:1] - 1'b1;
		rx0   = sb.right_rect[47:37];
		ry0   = sb.right_rect[35:25];
		rx1   = rx0 + sb.right_rect[23:13] - 1'b1;
		ry1   = ry0 + sb.right_rect[11:1] - 1'b1;
		s_thr = thr_of(sb.straight_level);
		r_thr = thr_of(sb.right_level);
		// A frame end with both regions empty gives nothing.
		send_pixel(16'd1000, '0, '0, 1'b1);
		// Zero depth is never counted.
		send_pixel('0, sx0, sy0, 1'b0);
		send_pixel('0, rx0, ry0, 1'b1);
		// Depth extremes at opposite corners, frame end on the far image corner.
		send_pixel('1, sx0, sy0, 1'b0);
		send_pixel(16'd1, rx1, ry1, 1'b0);
		send_pixel('1, '1, '1, 1'b1);
		// Pixels just past each edge stay out; the mean then sits on and below
		// the threshold, and the frame-end pixel itself is counted.
		send_pixel(16'd1, sx0 - 1'b1, sy0, 1'b0);
		send_pixel(16'd1, sx1 + 1'b1, sy1, 1'b0);
		send_pixel(16'd1, sx0, sy1 + 1'b1, 1'b0);
		send_pixel(16'd1, rx0, ry0 - 1'b1, 1'b0);
		send_pixel(s_thr, sx1, sy1, 1'b0);
		send_pixel(r_thr - 1'b1, rx0, ry1, 1'b1);
		// Only one region filled: no flags item, the old flags stay; then both again.
		send_pixel(16'd500, sx0, sy0, 1'b1);
		send_pixel(16'd1, sx1, sy0, 1'b0);
		send_pixel('1, rx1, ry0, 1'b1);
	endtask

	task automatic random_frames(input int unsigned items);
		int unsigned sent;
		int unsigned n;
		int unsigned shape;
		int unsigned kind;
		bit s_low;
		bit r_low;
		logic fe;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] rw;
		sent = 0;
		while (sent < items) begin
			n     = $urandom_range(2, 10);
			shape = $urandom_range(0, 9);
			s_low = 1'($urandom_range(0, 1));
			r_low = 1'($urandom_range(0, 1));
			for (int i = 0; i < n; i++) begin
				fe   = (i == n - 1);
				kind = $urandom_range(0, 19);
				if (shape == 9) begin
					send_pixel(16'($urandom()), 11'($urandom()), 11'($urandom()), fe);
				end else if (i == 0 || (shape == 8 && kind < 16) || kind < 8) begin
					region_pixel(sb.straight_rect, thr_of(sb.straight_level), s_low, fe);
				end else if (i == 1 || kind < 16) begin
					region_pixel(sb.right_rect, thr_of(sb.right_level), r_low, fe);
				end else if (kind < 18) begin
					point_in(sb.straight_rect, c, rw);
					if (kind == 16)
						c = sb.straight_rect[47:37] - 1'b1;
					else
						rw = sb.straight_rect[35:25] + sb.straight_rect[11:1];
					send_pixel(16'($urandom_range(1, 65535)), c, rw, fe);
				end else begin
					point_in(sb.right_rect, c, rw);
					send_pixel('0, c, rw, fe);
				end
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_frames();
		random_frames(60);
		drain();
		load_settings(roi_rect(), roi_rect(), $urandom_range(0, 4000),
			$urandom_range(0, 4000), $urandom_range(0, 500));
		random_frames(70);
		drain();
		load_settings('0, '1, '1, '1, '0);
		random_frames(20);
		drain();
		load_settings('1, roi_rect(), 48'hFFFF, '0, '0);
		random_frames(50);
		drain();
		load_settings(roi_rect(), roi_rect(), 48'hFFFF, $urandom_range(0, 65535), 48'hFFFF);
		random_frames(50);
		drain();
		load_settings(roi_rect(), roi_rect(), 48'({$urandom(), $urandom()}),
			48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
		random_frames(70);
		repeat (2) begin
			drain();
			load_settings(roi_rect(), roi_rect(), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 3000));
			random_frames(50);
		end
		drain();
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
